@@ design/assert_macros.svh @@
// Assertion macros shared by the backoff controller modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define CCB_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication
`define CCB_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define CCB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/ccb_pkg.sv @@
// Types, codes and helpers of the CSMA-CA backoff controller
`timescale 1ns / 1ps

package ccb_pkg;

  localparam int CFG_AW = 5;

  typedef enum logic [1:0] {
    FN_NEW     = 2'd0,
    FN_TIMEOUT = 2'd1,
    FN_CCA     = 2'd2,
    FN_ACK     = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    PM_SETUP = 2'd0,
    PM_SLEEP = 2'd1,
    PM_CAP   = 2'd2,
    PM_GTS   = 2'd3
  } period_t;

  typedef enum logic [1:0] {
    CCA_CLEAR    = 2'd0,
    CCA_BUSY     = 2'd1,
    CCA_INVALID  = 2'd2,
    CCA_NOT_RDY  = 2'd3
  } cca_t;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_BACKOFF   = 3'd1,
    ACT_CCA_UNIT  = 3'd2,
    ACT_CCA_DELAY = 3'd3,
    ACT_TRANSMIT  = 3'd4,
    ACT_FAILED    = 3'd5,
    ACT_SUCCESS   = 3'd6,
    ACT_RADIO_RX  = 3'd7
  } act_t;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_SLOTTED     = 3'd0;
  localparam logic [2:0] REG_MIN_BE      = 3'd1;
  localparam logic [2:0] REG_MAX_BE      = 3'd2;
  localparam logic [2:0] REG_MAX_BACKOFF = 3'd3;
  localparam logic [2:0] REG_MAX_RETRY   = 3'd4;
  localparam logic [2:0] REG_BATT_EXT    = 3'd5;

  typedef struct packed {
    logic       slotted_mode;
    logic [3:0] min_backoff_exp;
    logic [3:0] max_backoff_exp;
    logic [2:0] max_csma_backoffs;
    logic [3:0] max_frame_retries;
    logic       battery_life_ext;
  } cfg_t;

  typedef struct packed {
    func_t      func;
    period_t    period_mode;
    cca_t       cca_code;
    logic [7:0] random_value;
    logic       is_broadcast;
    logic [3:0] retries_requested;
    logic       gts_only;
    logic       timer_pending;
  } in_item_t;

  typedef struct packed {
    act_t       action;
    logic [7:0] backoff_units;
    logic       align_slot;
    logic       ack_expected;
  } res_t;

  typedef struct packed {
    act_t       action;
    logic [7:0] backoff_units;
    logic       align_slot;
    logic       ack_expected;
    logic [3:0] retries_left;
    logic       last;
  } out_item_t;

  // core -> result queue write group
  typedef struct packed {
    logic [1:0] n;
    out_item_t  item0;
    out_item_t  item1;
  } qwr_t;

  function automatic res_t plain_res(act_t act);
    res_t r;
    r.action        = act;
    r.backoff_units = 8'd0;
    r.align_slot    = 1'b0;
    r.ack_expected  = 1'b0;
    return r;
  endfunction

  // draw max(1, rnd & (2^be - 1)); exponent 8 and up takes the whole byte
  function automatic res_t backoff_res(logic [3:0] be, logic [7:0] rnd, logic slotted);
    res_t       r;
    logic [7:0] mask;
    logic [7:0] units;
    mask = be[3] ? 8'hFF : ((8'd1 << be[2:0]) - 8'd1);
    units = rnd & mask;
    r.action        = ACT_BACKOFF;
    r.backoff_units = (units == 8'd0) ? 8'd1 : units;
    r.align_slot    = slotted;
    r.ack_expected  = 1'b0;
    return r;
  endfunction

endpackage

@@ design/csma_ca_backoff_controller_unit.sv @@
// Top level of the CSMA-CA backoff and retry controller
//
//  Channel | Direction | Handshake                    | Contents
//  in_     | slave     | tvalid/tready                | one MAC event
//  out_    | master    | tvalid/tready, tlast ends set| one action per transaction
//  cfg_    | APB slave | psel/penable, pready tied hi | six control registers
//
// An event transaction is taken every cycle while the result queue has room for
// two results; it waits in a stage register until the queue has room, and its
// results then enter the queue, whose head drives out_. A new packet replacing
// an active one can yield two result transactions; all other events yield at
// most one. rst_n is synchronous; no clearing pass is needed after reset. A
// stalled out_ side backs up into in_tready once the queue is nearly full.
`timescale 1ns / 1ps

module csma_ca_backoff_controller_unit #(
  parameter int OUT_QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // period_mode[1:0], cca_code[3:2], random_value[11:4], is_broadcast[12],
  // retries_requested[16:13], gts_only[17], timer_pending[18], zero fill
  input  logic [23:0] in_tdata,
  // func[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // action[2:0], backoff_units[10:3], align_slot[11], ack_expected[12],
  // retries_left[16:13], zero fill
  output logic [23:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [ccb_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  ccb_pkg::cfg_t      cfg;
  ccb_pkg::in_item_t  ev_item;
  ccb_pkg::qwr_t      q_wr;
  ccb_pkg::out_item_t out_item;
  logic               q_room;

  assign ev_item.func              = ccb_pkg::func_t'(in_tuser);
  assign ev_item.period_mode       = ccb_pkg::period_t'(in_tdata[1:0]);
  assign ev_item.cca_code          = ccb_pkg::cca_t'(in_tdata[3:2]);
  assign ev_item.random_value      = in_tdata[11:4];
  assign ev_item.is_broadcast      = in_tdata[12];
  assign ev_item.retries_requested = in_tdata[16:13];
  assign ev_item.gts_only          = in_tdata[17];
  assign ev_item.timer_pending     = in_tdata[18];

  ccb_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  ccb_event_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .ev_valid (in_tvalid),
    .ev_ready (in_tready),
    .ev_item  (ev_item),
    .q_room   (q_room),
    .q_wr     (q_wr)
  );

  ccb_out_queue #(
    .DEPTH (OUT_QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_wr      (q_wr),
    .q_room    (q_room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (out_item)
  );

  assign out_tdata = {7'd0, out_item.retries_left, out_item.ack_expected,
                      out_item.align_slot, out_item.backoff_units, out_item.action};
  assign out_tlast = out_item.last;

endmodule

@@ design/ccb_cfg_regs.sv @@
// Configuration register file behind the APB-style port
`timescale 1ns / 1ps

module ccb_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [ccb_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready,
  output ccb_pkg::cfg_t             cfg
);

  ccb_pkg::cfg_t cfg_r, cfg_nxt;
  logic          wr_en;
  logic [2:0]    idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign idx        = cfg_paddr[ccb_pkg::CFG_AW-1:2];
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        ccb_pkg::REG_SLOTTED:     cfg_nxt.slotted_mode      = cfg_pwdata[0];
        ccb_pkg::REG_MIN_BE:      cfg_nxt.min_backoff_exp   = cfg_pwdata[3:0];
        ccb_pkg::REG_MAX_BE:      cfg_nxt.max_backoff_exp   = cfg_pwdata[3:0];
        ccb_pkg::REG_MAX_BACKOFF: cfg_nxt.max_csma_backoffs = cfg_pwdata[2:0];
        ccb_pkg::REG_MAX_RETRY:   cfg_nxt.max_frame_retries = cfg_pwdata[3:0];
        ccb_pkg::REG_BATT_EXT:    cfg_nxt.battery_life_ext  = cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ccb_pkg::REG_SLOTTED:     cfg_prdata = {31'd0, cfg_r.slotted_mode};
      ccb_pkg::REG_MIN_BE:      cfg_prdata = {28'd0, cfg_r.min_backoff_exp};
      ccb_pkg::REG_MAX_BE:      cfg_prdata = {28'd0, cfg_r.max_backoff_exp};
      ccb_pkg::REG_MAX_BACKOFF: cfg_prdata = {29'd0, cfg_r.max_csma_backoffs};
      ccb_pkg::REG_MAX_RETRY:   cfg_prdata = {28'd0, cfg_r.max_frame_retries};
      ccb_pkg::REG_BATT_EXT:    cfg_prdata = {31'd0, cfg_r.battery_life_ext};
      default:                  cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slotted_mode      <= 1'b0;
      cfg_r.min_backoff_exp   <= 4'd3;
      cfg_r.max_backoff_exp   <= 4'd5;
      cfg_r.max_csma_backoffs <= 3'd4;
      cfg_r.max_frame_retries <= 4'd3;
      cfg_r.battery_life_ext  <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ design/ccb_event_core.sv @@
// Event register, CSMA-CA state and single-pass step logic
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ccb_event_core (
  input  logic              clk,
  input  logic              rst_n,
  input  ccb_pkg::cfg_t     cfg,
  input  logic              ev_valid,
  output logic              ev_ready,
  input  ccb_pkg::in_item_t ev_item,
  input  logic              q_room,
  output ccb_pkg::qwr_t     q_wr
);

  logic              stage_v_r, stage_v_nxt;
  ccb_pkg::in_item_t stage_r;
  logic              fire;

  logic       pa_r, pg_r, aw_r;
  logic [3:0] al_r, be_r;
  logic [2:0] nb_r;
  logic [1:0] cw_r;
  logic       pa_nxt, pg_nxt, aw_nxt;
  logic [3:0] al_nxt, be_nxt;
  logic [2:0] nb_nxt;
  logic [1:0] cw_nxt;

  logic          first_fail, main_v, do_att;
  ccb_pkg::res_t main_res;
  logic [1:0]    cw_init;
  logic [3:0]    be_init;
  logic [4:0]    be_inc;
  logic [3:0]    nb_inc;

  assign ev_ready = !stage_v_r || q_room;
  assign fire     = stage_v_r && q_room;

  always_comb begin
    stage_v_nxt = stage_v_r;
    if (fire) stage_v_nxt = 1'b0;
    if (ev_valid && ev_ready) stage_v_nxt = 1'b1;
  end

  assign cw_init = cfg.slotted_mode ? 2'd2 : 2'd1;
  assign be_init = (cfg.battery_life_ext && cfg.min_backoff_exp > 4'd2) ? 4'd2
                                                                       : cfg.min_backoff_exp;
  assign be_inc  = {1'b0, be_r} + 5'd1;
  assign nb_inc  = {1'b0, nb_r} + 4'd1;

  always_comb begin
    pa_nxt     = pa_r;
    pg_nxt     = pg_r;
    aw_nxt     = aw_r;
    al_nxt     = al_r;
    be_nxt     = be_r;
    nb_nxt     = nb_r;
    cw_nxt     = cw_r;
    first_fail = 1'b0;
    main_v     = 1'b0;
    main_res   = ccb_pkg::plain_res(ccb_pkg::ACT_NONE);
    do_att     = 1'b0;

    case (stage_r.func)
      ccb_pkg::FN_NEW: begin
        // an active packet is dropped as failed before the new one takes over
        first_fail = pa_r;
        pa_nxt     = 1'b1;
        pg_nxt     = stage_r.gts_only;
        if (stage_r.is_broadcast) begin
          al_nxt = 4'd1;
          aw_nxt = 1'b0;
        end else begin
          al_nxt = (stage_r.retries_requested == 4'd0) ? cfg.max_frame_retries
                                                        : stage_r.retries_requested;
          aw_nxt = 1'b1;
        end
        do_att = !stage_r.timer_pending;
      end
      ccb_pkg::FN_TIMEOUT: do_att = 1'b1;
      ccb_pkg::FN_CCA: begin
        if (pa_r && stage_r.period_mode != ccb_pkg::PM_GTS &&
            stage_r.period_mode != ccb_pkg::PM_SLEEP) begin
          case (stage_r.cca_code)
            ccb_pkg::CCA_CLEAR: begin
              main_v = 1'b1;
              if (cw_r > 2'd1) begin
                cw_nxt   = cw_r - 2'd1;
                main_res = ccb_pkg::plain_res(ccb_pkg::ACT_CCA_UNIT);
              end else begin
                cw_nxt   = 2'd0;
                if (al_r != 4'd0) al_nxt = al_r - 4'd1;
                main_res = ccb_pkg::plain_res(ccb_pkg::ACT_TRANSMIT);
                main_res.ack_expected = aw_r;
              end
            end
            ccb_pkg::CCA_BUSY: begin
              cw_nxt = cw_init;
              be_nxt = (be_inc > {1'b0, cfg.max_backoff_exp}) ? cfg.max_backoff_exp
                                                                : be_inc[3:0];
              nb_nxt = (nb_inc > 4'd7) ? 3'd7 : nb_inc[2:0];
              if (nb_inc > {1'b0, cfg.max_csma_backoffs}) begin
                // attempt spent, start over
                if (al_r != 4'd0) al_nxt = al_r - 4'd1;
                do_att = 1'b1;
              end else begin
                main_v   = 1'b1;
                main_res = ccb_pkg::backoff_res(be_nxt, stage_r.random_value,
                                                cfg.slotted_mode);
              end
            end
            ccb_pkg::CCA_INVALID: begin
              main_v   = 1'b1;
              main_res = ccb_pkg::plain_res(ccb_pkg::ACT_CCA_DELAY);
            end
            default: begin
              main_v   = 1'b1;
              main_res = ccb_pkg::plain_res(ccb_pkg::ACT_RADIO_RX);
            end
          endcase
        end
      end
      default: begin
        if (pa_r) begin
          pa_nxt   = 1'b0;
          pg_nxt   = 1'b0;
          aw_nxt   = 1'b0;
          main_v   = 1'b1;
          main_res = ccb_pkg::plain_res(ccb_pkg::ACT_SUCCESS);
        end
      end
    endcase

    // attempt start: only in CAP or GTS with a packet held
    if (do_att && pa_nxt && (stage_r.period_mode == ccb_pkg::PM_CAP ||
                             stage_r.period_mode == ccb_pkg::PM_GTS)) begin
      if (al_nxt == 4'd0) begin
        pa_nxt   = 1'b0;
        pg_nxt   = 1'b0;
        aw_nxt   = 1'b0;
        main_v   = 1'b1;
        main_res = ccb_pkg::plain_res(ccb_pkg::ACT_FAILED);
      end else if (stage_r.period_mode == ccb_pkg::PM_GTS) begin
        al_nxt   = al_nxt - 4'd1;
        main_v   = 1'b1;
        main_res = ccb_pkg::plain_res(ccb_pkg::ACT_TRANSMIT);
        main_res.ack_expected = aw_nxt;
      end else if (!pg_nxt) begin
        be_nxt   = be_init;
        nb_nxt   = 3'd0;
        cw_nxt   = cw_init;
        main_v   = 1'b1;
        main_res = ccb_pkg::backoff_res(be_init, stage_r.random_value, cfg.slotted_mode);
      end
    end
  end

  always_comb begin
    q_wr.n = fire ? ({1'b0, first_fail} + {1'b0, main_v}) : 2'd0;
    q_wr.item0.action        = first_fail ? ccb_pkg::ACT_FAILED : main_res.action;
    q_wr.item0.backoff_units = first_fail ? 8'd0 : main_res.backoff_units;
    q_wr.item0.align_slot    = first_fail ? 1'b0 : main_res.align_slot;
    q_wr.item0.ack_expected  = first_fail ? 1'b0 : main_res.ack_expected;
    q_wr.item0.retries_left  = al_nxt;
    q_wr.item0.last          = !(first_fail && main_v);
    q_wr.item1.action        = main_res.action;
    q_wr.item1.backoff_units = main_res.backoff_units;
    q_wr.item1.align_slot    = main_res.align_slot;
    q_wr.item1.ack_expected  = main_res.ack_expected;
    q_wr.item1.retries_left  = al_nxt;
    q_wr.item1.last          = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (ev_valid && ev_ready) stage_r <= ev_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
      pa_r      <= 1'b0;
      pg_r      <= 1'b0;
      aw_r      <= 1'b0;
      al_r      <= 4'd0;
      be_r      <= 4'd0;
      nb_r      <= 3'd0;
      cw_r      <= 2'd0;
    end else begin
      stage_v_r <= stage_v_nxt;
      if (fire) begin
        pa_r <= pa_nxt;
        pg_r <= pg_nxt;
        aw_r <= aw_nxt;
        al_r <= al_nxt;
        be_r <= be_nxt;
        nb_r <= nb_nxt;
        cw_r <= cw_nxt;
      end
    end
  end

  `CCB_ASSERT_IMPLY(a_two_only_new, fire && q_wr.n == 2'd2, stage_r.func == ccb_pkg::FN_NEW, "two results from an event other than new packet")
  `CCB_ASSERT_NEXT(a_end_clears, fire && main_v && (main_res.action == ccb_pkg::ACT_FAILED || main_res.action == ccb_pkg::ACT_SUCCESS), !pa_r && !aw_r, "packet still active after it ended")
  `CCB_ASSERT_IMPLY(a_no_ready_no_room, !ev_ready, stage_v_r && !q_room, "input stalled while stage can drain")

endmodule

@@ design/ccb_out_queue.sv @@
// Result queue: takes up to two results per cycle, hands out one while out_ready is high
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ccb_out_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ccb_pkg::qwr_t       q_wr,
  output logic                q_room,
  output logic                out_valid,
  input  logic                out_ready,
  output ccb_pkg::out_item_t  out_item
);

  localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ccb_pkg::out_item_t mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r, wp_nxt, rp_nxt, wp1, wp2;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          rd;

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign rd        = out_valid && out_ready;
  assign out_valid = cnt_r != '0;
  assign out_item  = mem_r[rp_r];
  assign q_room    = cnt_r <= CW'(DEPTH - 2);
  assign wp1       = ptr_inc(wp_r);
  assign wp2       = ptr_inc(wp1);

  always_comb begin
    wp_nxt  = wp_r;
    if (q_wr.n == 2'd1) wp_nxt = wp1;
    if (q_wr.n == 2'd2) wp_nxt = wp2;
    rp_nxt  = rd ? ptr_inc(rp_r) : rp_r;
    cnt_nxt = cnt_r + CW'(q_wr.n) - CW'(rd);
  end

  always_ff @(posedge clk) begin
    if (q_wr.n != 2'd0) mem_r[wp_r] <= q_wr.item0;
    if (q_wr.n == 2'd2) mem_r[wp1]  <= q_wr.item1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `CCB_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CW'(DEPTH), "result queue count beyond depth")
  `CCB_ASSERT_IMPLY(a_no_overflow, q_wr.n != 2'd0, ({1'b0, cnt_r} + (CW+1)'(q_wr.n)) <= (CW+1)'(DEPTH), "write into a full result queue")
  `CCB_ASSERT_NEXT(a_drain_count, rd && q_wr.n == 2'd0, cnt_r == $past(cnt_r) - CW'(1), "count off after a read")

endmodule
